/* src/sparse_slot_list_assert.svh */
// Assertion macros for the sparse slot list RTL.
// Included by the modules that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef SPARSE_SLOT_LIST_ASSERT_SVH
`define SPARSE_SLOT_LIST_ASSERT_SVH
`ifndef SYNTHESIS
// checked only while out of reset
`define SSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked during reset as well
`define SSL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SSL_ASSERT(lbl, prop, msg)
`define SSL_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* src/ssl_pkg.sv */
// Shared types and constants for the sparse slot list.
// Used by ssl_ctrl, ssl_dpath and the sparse_slot_list top level.
`default_nettype none
package ssl_pkg;

  localparam int unsigned SlotsDefault = 32;
  localparam int unsigned FuncW        = 2;
  localparam int unsigned PosW         = 5;
  localparam int unsigned HandleW      = 32;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned LiveW        = 6;

  typedef enum logic [FuncW-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_GET    = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_NULL      = 2'd3
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic load;    // latch a new transaction, rewind the scan
    logic step;    // advance the scan by one slot
    logic commit;  // apply the operation at the hit slot
    logic finish;  // close without a hit: clear, null handle or miss
  } ssl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic trivial; // clear or null add, no scan needed
    logic hit;     // current slot satisfies the operation
    logic last;    // scan is at the final slot
  } ssl_sts_t;

endpackage
`default_nettype wire

/* src/ssl_ctrl.sv */
// Sequencer for the sparse slot list: accept, scan, commit, respond.
// Depends on ssl_pkg and sparse_slot_list_assert.svh.
`default_nettype none
`include "sparse_slot_list_assert.svh"
module ssl_ctrl
  import ssl_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire ssl_sts_t sts_i,
  output ssl_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_ACT  = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (sts_i.trivial) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_RESP;
        end else if (sts_i.hit) begin
          state_d = ST_ACT;
        end else if (sts_i.last) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_RESP;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_ACT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_RESP;
      end
      ST_RESP: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_RESP);

  `SSL_ASSERT(a_ready_valid_excl, !(in_ready_o && out_valid_o), "ready and valid both high")
  `SSL_ASSERT(a_act_after_hit, (state_q == ST_ACT) |-> $past(state_q == ST_SCAN && sts_i.hit), "commit without a scan hit")

endmodule
`default_nettype wire

/* src/ssl_dpath.sv */
// Datapath for the sparse slot list: occupancy marks, handle memory, scan
// pointer, rank counter, live count and result registers. Depends on ssl_pkg.
`default_nettype none
`include "sparse_slot_list_assert.svh"
module ssl_dpath
  import ssl_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ssl_cmd_t           cmd_i,
  output ssl_sts_t                sts_o,
  input  wire logic [FuncW-1:0]   func_i,
  input  wire logic [PosW-1:0]    position_i,
  input  wire logic [HandleW-1:0] handle_in_i,
  output logic [HandleW-1:0]      handle_out_o,
  output logic [StatusW-1:0]      status_o,
  output logic [LiveW-1:0]        live_count_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);

  logic [SLOTS-1:0]   occ_q, occ_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [IdxW-1:0]    idx_q;
  logic [PosW-1:0]    rank_q;
  func_e              func_q;
  logic [HandleW-1:0] handle_q;
  logic [HandleW-1:0] mem_q [SLOTS];
  logic [HandleW-1:0] rd_data_q;
  logic [HandleW-1:0] res_handle_q, res_handle_d;
  status_e            res_status_q, res_status_d;
  logic               occ_cur;
  logic               mem_we;
  logic [CntW+LiveW-1:0] count_ext;

  assign occ_cur = occ_q[idx_q];

  always_comb begin
    sts_o.trivial = (func_q == FUNC_CLEAR) || (func_q == FUNC_ADD && handle_q == '0);
    sts_o.hit     = (func_q == FUNC_ADD) ? !occ_cur : (occ_cur && rank_q == '0);
    sts_o.last    = (idx_q == IdxW'(SLOTS - 1));
  end

  assign mem_we = cmd_i.commit && (func_q == FUNC_ADD);

  always_comb begin
    occ_d        = occ_q;
    count_d      = count_q;
    res_handle_d = res_handle_q;
    res_status_d = res_status_q;
    if (cmd_i.finish) begin
      res_handle_d = '0;
      unique case (func_q)
        FUNC_CLEAR: begin
          occ_d        = '0;
          count_d      = '0;
          res_status_d = STATUS_OK;
        end
        FUNC_ADD:    res_status_d = (handle_q == '0) ? STATUS_NULL : STATUS_FULL;
        FUNC_GET,
        FUNC_REMOVE: res_status_d = STATUS_NOT_FOUND;
        default:     res_status_d = STATUS_NOT_FOUND;
      endcase
    end else if (cmd_i.commit) begin
      res_handle_d = '0;
      res_status_d = STATUS_OK;
      unique case (func_q)
        FUNC_ADD: begin
          occ_d[idx_q] = 1'b1;
          count_d      = count_q + CntW'(1);
        end
        FUNC_GET: res_handle_d = rd_data_q;
        FUNC_REMOVE: begin
          occ_d[idx_q] = 1'b0;
          if (count_q != '0) begin
            count_d = count_q - CntW'(1);
          end
        end
        default: res_status_d = STATUS_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= '0;
      count_q <= '0;
    end else begin
      occ_q   <= occ_d;
      count_q <= count_d;
    end
  end

  // scan pointer and transaction fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q    <= '0;
      rank_q   <= position_i;
      func_q   <= func_e'(func_i);
      handle_q <= handle_in_i;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + IdxW'(1);
      if (occ_cur) begin
        rank_q <= rank_q - PosW'(1);
      end
    end
    res_handle_q <= res_handle_d;
    res_status_q <= res_status_d;
  end

  // handle memory; read data is valid the cycle after the hit slot is held
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[idx_q] <= handle_q;
    end
    rd_data_q <= mem_q[idx_q];
  end

  assign count_ext    = {{LiveW{1'b0}}, count_q};
  assign handle_out_o = res_handle_q;
  assign status_o     = res_status_q;
  assign live_count_o = count_ext[LiveW-1:0];

  `SSL_ASSERT(a_count_matches_marks, $countones(occ_q) == count_q, "live count out of step with marks")
  `SSL_ASSERT(a_add_hits_free, (cmd_i.commit && func_q == FUNC_ADD) |-> !occ_cur, "add committed on an occupied slot")

endmodule
`default_nettype wire

/* src/sparse_slot_list.sv */
// Sparse slot list: a fixed table of SLOTS handle slots with occupancy marks
// and a live count.
//
// Input channel (in_valid_i/in_ready_o) carries func_i, position_i and
// handle_in_i: add a nonzero handle to the lowest free slot, get or remove
// the position-th occupied slot, or clear everything. Every transaction
// yields one result on the output channel (out_valid_o/out_ready_i):
// handle_out_o, status_o and live_count_o (count after the operation).
// One transaction is in flight at a time. A scan over the occupancy marks
// visits one slot per cycle, so an add, get or remove scans from slot 0 up
// to its hit or the final slot, then commits on a hit before out_valid_o
// rises. Clear and null-handle adds skip the scan. in_ready_o returns the
// cycle after the result transaction.
// The result is held in registers while the receiver stalls; no new input is
// taken until it is delivered. Reset empties every slot and zeroes the count;
// the handle memory is not cleared; only occupied slots reach handle_out_o.
// Depends on ssl_pkg, ssl_ctrl and ssl_dpath.
`default_nettype none
module sparse_slot_list
  import ssl_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [FuncW-1:0]   func_i,
  input  wire logic [PosW-1:0]    position_i,
  input  wire logic [HandleW-1:0] handle_in_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [HandleW-1:0]      handle_out_o,
  output logic [StatusW-1:0]      status_o,
  output logic [LiveW-1:0]        live_count_o
);

  ssl_cmd_t cmd;
  ssl_sts_t sts;

  ssl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ssl_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .func_i       (func_i),
    .position_i   (position_i),
    .handle_in_i  (handle_in_i),
    .handle_out_o (handle_out_o),
    .status_o     (status_o),
    .live_count_o (live_count_o)
  );

endmodule
`default_nettype wire

/* sim/tb_sparse_slot_list.sv */
// Self-checking testbench for sparse_slot_list: directed and random add, get,
// remove and clear traffic with bursty input and a stalling result receiver.
// Depends on ssl_pkg and the sparse_slot_list RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_sparse_slot_list;
  import ssl_pkg::*;

  localparam int unsigned Slots    = SlotsDefault;
  localparam int unsigned HoldLen  = 400;

  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic [StatusW-1:0] status;
    logic [LiveW-1:0]   count;
  } slot_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready_o;
  func_e              func = FUNC_ADD;
  logic [PosW-1:0]    position = '0;
  logic [HandleW-1:0] handle_in = '0;
  logic               out_valid_o;
  logic               out_ready = 1'b0;
  logic [HandleW-1:0] handle_out_o;
  logic [StatusW-1:0] status_o;
  logic [LiveW-1:0]   live_count_o;

  sparse_slot_list #(.SLOTS(Slots)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .func_i      (func),
    .position_i  (position),
    .handle_in_i (handle_in),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .handle_out_o(handle_out_o),
    .status_o    (status_o),
    .live_count_o(live_count_o)
  );

  always #1 clk_i = ~clk_i;

  // Table shadow and expected results
  bit                 slot_used [Slots];
  logic [HandleW-1:0] slot_val  [Slots];
  int unsigned        used_count;
  slot_result_t       expected_results[$];

  int unsigned n_items, n_results, n_errors;
  int unsigned n_status [4];
  int unsigned burst_left;
  int unsigned hold_requested, hold_served;

  function automatic int unsigned slot_of_rank(int unsigned rank);
    int unsigned left;
    left = rank;
    for (int unsigned s = 0; s < Slots; s++) begin
      if (slot_used[s]) begin
        if (left == 0) return s;
        left--;
      end
    end
    return Slots;
  endfunction

  function automatic void table_apply(func_e f, logic [PosW-1:0] p, logic [HandleW-1:0] h);
    slot_result_t r;
    int unsigned  s;
    r = '0;
    r.status = STATUS_OK;
    case (f)
      FUNC_ADD: begin
        if (h == '0) begin
          r.status = STATUS_NULL;
        end else begin
          s = 0;
          while (s < Slots && slot_used[s]) s++;
          if (s >= Slots) begin
            r.status = STATUS_FULL;
          end else begin
            slot_used[s] = 1'b1;
            slot_val[s]  = h;
            used_count++;
          end
        end
      end
      FUNC_GET: begin
        s = slot_of_rank(p);
        if (s >= Slots) r.status = STATUS_NOT_FOUND;
        else r.handle = slot_val[s];
      end
      FUNC_REMOVE: begin
        s = slot_of_rank(p);
        if (s >= Slots) begin
          r.status = STATUS_NOT_FOUND;
        end else begin
          slot_used[s] = 1'b0;
          if (used_count > 0) used_count--;
        end
      end
      default: begin
        for (int unsigned k = 0; k < Slots; k++) slot_used[k] = 1'b0;
        used_count = 0;
      end
    endcase
    r.count = used_count[LiveW-1:0];
    n_status[r.status]++;
    expected_results.push_back(r);
  endfunction

  task automatic report_mismatch(string what, logic [HandleW-1:0] got, logic [HandleW-1:0] exp);
    if (n_errors < 30)
      $display("ERROR @%0t: %s got %0h expected %0h", $time, what, got, exp);
    n_errors++;
  endtask

  // Sends one transaction; the sender works in bursts separated by idle gaps.
  task automatic send_item(func_e f, logic [PosW-1:0] p, logic [HandleW-1:0] h);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid  <= 1'b1;
    func      <= f;
    position  <= p;
    handle_in <= h;
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    table_apply(f, p, h);
    n_items++;
  endtask

  // Result checker: values are stable from the falling edge to the accepting edge
  always @(negedge clk_i) begin
    slot_result_t e;
    if (rst_ni && out_valid_o && out_ready) begin
      n_results++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending, handle", handle_out_o, '0);
      end else begin
        e = expected_results.pop_front();
        if (handle_out_o !== e.handle) report_mismatch("handle_out", handle_out_o, e.handle);
        if (status_o !== e.status) report_mismatch("status", status_o, e.status);
        if (live_count_o !== e.count) report_mismatch("live_count", live_count_o, e.count);
      end
    end
  end

  // Receiver: changing stall patterns plus an on-demand long hold
  int unsigned hold_left, mode, mode_left, stall_left;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_served != hold_requested) begin
      hold_served++;
      hold_left = HoldLen - 1;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: begin
          // stall for a random run, then take one
          if (stall_left == 0) begin
            stall_left = $urandom_range(1, 8);
            out_ready <= 1'b1;
          end else begin
            stall_left--;
            out_ready <= 1'b0;
          end
        end
      endcase
    end
  end

  function automatic logic [HandleW-1:0] pick_handle();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return '1;
      2: return 32'h1 << $urandom_range(0, 31);
      3: return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_and_null();
    send_item(FUNC_GET, 5'd0, 32'h0);
    send_item(FUNC_REMOVE, 5'd0, 32'hFFFF_FFFF);
    send_item(FUNC_ADD, 5'd31, 32'h0);
    send_item(FUNC_ADD, 5'd0, 32'hFFFF_FFFF);
    send_item(FUNC_ADD, 5'd0, 32'h0000_0001);
    send_item(FUNC_ADD, 5'd0, 32'h8000_0000);
    send_item(FUNC_GET, 5'd0, 32'h0);
    send_item(FUNC_GET, 5'd2, 32'h0);
    send_item(FUNC_GET, 5'd3, 32'h0);
    send_item(FUNC_GET, 5'd31, 32'h0);
    send_item(FUNC_REMOVE, 5'd1, 32'h0);
    send_item(FUNC_GET, 5'd1, 32'h0);
    send_item(FUNC_ADD, 5'd0, 32'h5A5A_A5A5); // refills the freed middle slot
    send_item(FUNC_GET, 5'd1, 32'h0);
    send_item(FUNC_REMOVE, 5'd7, 32'h0);
    send_item(FUNC_CLEAR, 5'd31, 32'hFFFF_FFFF);
    send_item(FUNC_GET, 5'd0, 32'h0);
  endtask

  task automatic test_full_table();
    for (int unsigned k = 0; k < Slots; k++) send_item(FUNC_ADD, '0, pick_handle() | 32'h1);
    send_item(FUNC_ADD, 5'd0, 32'hDEAD_0001);
    send_item(FUNC_GET, 5'd31, 32'h0);
    send_item(FUNC_GET, 5'd0, 32'h0);
    send_item(FUNC_REMOVE, 5'd31, 32'h0);
    send_item(FUNC_REMOVE, 5'd0, 32'h0);
    send_item(FUNC_ADD, 5'd0, 32'h0);
    send_item(FUNC_ADD, 5'd0, 32'h1234_5678);
    send_item(FUNC_GET, 5'd0, 32'h0);
    send_item(FUNC_CLEAR, 5'd0, 32'h0);
  endtask

  // Long receiver hold while the sender keeps offering back to back
  task automatic test_backpressure();
    hold_requested++;
    burst_left = 40;
    for (int unsigned k = 0; k < 16; k++) send_item(FUNC_ADD, '0, pick_handle());
    for (int unsigned k = 0; k < 8; k++)
      send_item(FUNC_GET, PosW'($urandom_range(0, 31)), '0);
  endtask

  task automatic test_random_traffic();
    int unsigned add_weight, r;
    func_e       f;
    logic [PosW-1:0] p;
    for (int unsigned seg = 0; seg < 12; seg++) begin
      case (seg % 3)
        0: add_weight = 70;
        1: add_weight = 45;
        default: add_weight = 25;
      endcase
      for (int unsigned k = 0; k < 100; k++) begin
        r = $urandom_range(0, 99);
        if (r < add_weight) f = FUNC_ADD;
        else if (r < 98) f = $urandom_range(0, 1) ? FUNC_GET : FUNC_REMOVE;
        else f = FUNC_CLEAR;
        if (used_count > 0 && $urandom_range(0, 9) < 8) p = PosW'($urandom_range(0, used_count - 1));
        else p = PosW'($urandom_range(0, 31));
        send_item(f, p, pick_handle());
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_null();
    test_full_table();
    test_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (Slots + 8) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", expected_results.size(), '0);
    $display("Ran %0d transactions, checked %0d results; ok %0d, not found %0d,",
             n_items, n_results, n_status[STATUS_OK], n_status[STATUS_NOT_FOUND]);
    $display("table full %0d, null handle %0d, long receiver hold %0d time(s)",
             n_status[STATUS_FULL], n_status[STATUS_NULL], hold_served);
    if (n_errors == 0) begin
      $display("sparse_slot_list: match");
    end else begin
      $display("sparse_slot_list: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results pending", expected_results.size());
    $display("sparse_slot_list: mismatch");
    $finish;
  end

endmodule
`default_nettype wire
